>>> hw/rtl/framebuffer_dirty_flush_engine_unit_defines.svh
// assertion macros for the framebuffer dirty flush engine
// included by the rtl files that carry assertions, no other dependencies
`ifndef FRAMEBUFFER_DIRTY_FLUSH_ENGINE_UNIT_DEFINES_SVH
`define FRAMEBUFFER_DIRTY_FLUSH_ENGINE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define FDF_ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("fdf: property violated");
// trigger in one cycle implies a property in the next
`define FDF_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
	else $error("fdf: next-cycle property violated");
`else
`define FDF_ASSERT_HOLDS(label, clk, rst_n, prop)
`define FDF_ASSERT_NEXT(label, clk, rst_n, trig, prop)
`endif
`endif

>>> hw/rtl/fdf_pkg.sv
// shared sizes, operation codes and queue entry type of the flush engine
// no dependencies
`default_nettype none
package fdf_pkg;
	localparam int MAX_WIDTH   = 320;
	localparam int MAX_HEIGHT  = 320;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	// coordinate width follows the 9-bit screen size registers
	localparam int XW          = 9;
	localparam int OFS_W       = 8;

	typedef enum logic [1:0] {
		OP_FILL,
		OP_FLUSH_DIRTY,
		OP_FLUSH_REGION,
		OP_PULL
	} op_t;

	typedef struct packed {
		op_t            op;
		logic [XW-1:0]  left;
		logic [XW-1:0]  top;
		logic [XW-1:0]  right;
		logic [XW-1:0]  bottom;
		logic [15:0]    color;
	} q_entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/fdf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module fdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/fdf_front.sv
// front end: accepts commands, clips rectangles to the screen, queues operations
// depends on fdf_pkg
`default_nettype none
module fdf_front (
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [2:0]                  command,
	input  wire logic signed [15:0]          pos_x,
	input  wire logic signed [15:0]          pos_y,
	input  wire logic signed [15:0]          rect_width,
	input  wire logic signed [15:0]          rect_height,
	input  wire logic [15:0]                 pixel_color,
	input  wire logic [fdf_pkg::XW-1:0]      eff_w,
	input  wire logic [fdf_pkg::XW-1:0]      eff_h,
	input  wire logic                        init_done,
	input  wire logic                        q_full,
	output logic                             q_push,
	output fdf_pkg::q_entry_t                q_entry
);
	import fdf_pkg::*;

	localparam logic [2:0] CMD_WRITE_PIXEL  = 3'd0;
	localparam logic [2:0] CMD_FILL_RECT    = 3'd1;
	localparam logic [2:0] CMD_FLUSH_DIRTY  = 3'd2;
	localparam logic [2:0] CMD_FLUSH_REGION = 3'd3;
	localparam logic [2:0] CMD_PULL_BYTE    = 3'd4;

	logic signed [17:0] x_s, y_s, w_s, h_s, x_end, y_end;
	logic signed [17:0] x0, y0, x1, y1, x1m, y1m, lim_w, lim_h;
	logic               clip_empty, keep, accept;

	assign accept = push && !full;
	assign full   = q_full || !init_done;

	always_comb begin
		x_s   = {{2{pos_x[15]}}, pos_x};
		y_s   = {{2{pos_y[15]}}, pos_y};
		if (command == CMD_WRITE_PIXEL) begin
			w_s = 18'sd1;
			h_s = 18'sd1;
		end else begin
			w_s = {{2{rect_width[15]}}, rect_width};
			h_s = {{2{rect_height[15]}}, rect_height};
		end
		lim_w = $signed({{(18-XW){1'b0}}, eff_w});
		lim_h = $signed({{(18-XW){1'b0}}, eff_h});
		x_end = x_s + w_s;
		y_end = y_s + h_s;
		x0    = x_s[17] ? 18'sd0 : x_s;
		y0    = y_s[17] ? 18'sd0 : y_s;
		x1    = (x_end > lim_w) ? lim_w : x_end;
		y1    = (y_end > lim_h) ? lim_h : y_end;
		x1m   = x1 - 18'sd1;
		y1m   = y1 - 18'sd1;
		clip_empty = (x1 <= x0) || (y1 <= y0);
	end

	always_comb begin
		keep           = 1'b0;
		q_entry.op     = OP_PULL;
		q_entry.left   = x0[XW-1:0];
		q_entry.top    = y0[XW-1:0];
		q_entry.right  = x1m[XW-1:0];
		q_entry.bottom = y1m[XW-1:0];
		q_entry.color  = pixel_color;
		unique case (command) inside
			CMD_WRITE_PIXEL, CMD_FILL_RECT: begin
				keep       = !clip_empty;
				q_entry.op = OP_FILL;
			end
			CMD_FLUSH_DIRTY: begin
				keep       = 1'b1;
				q_entry.op = OP_FLUSH_DIRTY;
			end
			CMD_FLUSH_REGION: begin
				keep       = !clip_empty;
				q_entry.op = OP_FLUSH_REGION;
			end
			CMD_PULL_BYTE: begin
				keep       = 1'b1;
				q_entry.op = OP_PULL;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_push = accept && keep;
endmodule
`default_nettype wire

>>> hw/rtl/fdf_queue.sv
// two-entry operation queue between front and back end
// depends on fdf_pkg
`default_nettype none
module fdf_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  fdf_pkg::q_entry_t wr_data,
	output logic             full,
	input  wire logic        rd_en,
	output fdf_pkg::q_entry_t rd_data,
	output logic             empty
);
	import fdf_pkg::*;

	q_entry_t   entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/fdf_back.sv
// back end: frame store clear, fills, dirty box, flush stream and result register
// depends on fdf_pkg, fdf_ram and the assertion macro header
`include "framebuffer_dirty_flush_engine_unit_defines.svh"
`default_nettype none
module fdf_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  fdf_pkg::q_entry_t              q_head,
	input  wire logic                      q_empty,
	output logic                           q_pop,
	output logic                           init_done,
	input  wire logic [fdf_pkg::XW-1:0]    eff_w,
	input  wire logic [fdf_pkg::XW-1:0]    eff_h,
	input  wire logic [fdf_pkg::OFS_W-1:0] col_off,
	input  wire logic [fdf_pkg::OFS_W-1:0] row_off,
	input  wire logic                      pop,
	output logic                           empty,
	output logic                           has_byte,
	output logic                           data_not_command,
	output logic [7:0]                     out_byte,
	output logic                           last_of_flush
);
	import fdf_pkg::*;

	localparam logic [7:0] PANEL_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] PANEL_ROW_SET      = 8'h2B;
	localparam logic [7:0] PANEL_MEMORY_WRITE = 8'h2C;
	localparam logic [3:0] HDR_BYTES          = 4'd11;
	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR    = 4'b0001,
		ST_IDLE     = 4'b0010,
		ST_FILL     = 4'b0100,
		ST_PULL_OUT = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [XW-1:0]     fx_q, fy_q;
	logic              dirty_q;
	logic [XW-1:0]     dl_q, dt_q, dr_q, db_q;
	logic              busy_q;
	logic [XW-1:0]     wl_q, wt_q, wr_q, wb_q;
	logic [3:0]        hdr_q;
	logic              phase_q;
	logic [XW-1:0]     px_q, py_q;
	logic              out_valid_q, out_has_q, out_dnc_q, out_last_q;
	logic [7:0]        out_byte_q;

	logic [2*XW:0]     fill_sum, pull_sum;
	logic [ADDR_W-1:0] fill_addr, pull_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata, mem_rdata;
	logic              out_free, fill_last, pix_last;
	logic [XW:0]       dx1, dy1, dx1m, dy1m;
	logic              dirty_clip_empty;
	logic [XW:0]       cx0, cx1, ry0, ry1;
	logic [7:0]        hdr_byte;

	assign fill_sum  = (2*XW+1)'(fy_q * eff_w) + (2*XW+1)'(fx_q);
	assign pull_sum  = (2*XW+1)'(py_q * eff_w) + (2*XW+1)'(px_q);
	assign fill_addr = ADDR_W'(fill_sum);
	assign pull_addr = ADDR_W'(pull_sum);
	assign out_free  = !out_valid_q || pop;
	assign fill_last = (fx_q == q_head.right) && (fy_q == q_head.bottom);
	assign pix_last  = phase_q && (px_q == wr_q) && (py_q == wb_q);
	assign init_done = (state_q != ST_CLEAR);

	// dirty box clipped again to the current screen size
	always_comb begin
		dx1  = ({1'b0, dr_q} + 1'b1 > {1'b0, eff_w}) ? {1'b0, eff_w} : {1'b0, dr_q} + 1'b1;
		dy1  = ({1'b0, db_q} + 1'b1 > {1'b0, eff_h}) ? {1'b0, eff_h} : {1'b0, db_q} + 1'b1;
		dx1m = dx1 - 1'b1;
		dy1m = dy1 - 1'b1;
		dirty_clip_empty = (dx1 <= {1'b0, dl_q}) || (dy1 <= {1'b0, dt_q});
	end

	always_comb begin
		cx0 = {1'b0, wl_q} + (XW+1)'(col_off);
		cx1 = {1'b0, wr_q} + (XW+1)'(col_off);
		ry0 = {1'b0, wt_q} + (XW+1)'(row_off);
		ry1 = {1'b0, wb_q} + (XW+1)'(row_off);
		unique case (hdr_q)
			4'd0:    hdr_byte = PANEL_COLUMN_SET;
			4'd1:    hdr_byte = 8'(cx0 >> 8);
			4'd2:    hdr_byte = cx0[7:0];
			4'd3:    hdr_byte = 8'(cx1 >> 8);
			4'd4:    hdr_byte = cx1[7:0];
			4'd5:    hdr_byte = PANEL_ROW_SET;
			4'd6:    hdr_byte = 8'(ry0 >> 8);
			4'd7:    hdr_byte = ry0[7:0];
			4'd8:    hdr_byte = 8'(ry1 >> 8);
			4'd9:    hdr_byte = ry1[7:0];
			4'd10:   hdr_byte = PANEL_MEMORY_WRITE;
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_addr;
		mem_wdata = q_head.color;
		q_pop     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 16'h0000;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_head.op) inside
						OP_FLUSH_DIRTY, OP_FLUSH_REGION: q_pop = 1'b1;
						OP_PULL: q_pop = out_free && !(busy_q && hdr_q == HDR_BYTES);
						default: q_pop = 1'b0;
					endcase
				end
			end
			ST_FILL: begin
				mem_we = 1'b1;
				q_pop  = fill_last;
			end
			ST_PULL_OUT: begin
				q_pop = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	fdf_ram #(
		.WIDTH(16),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pull_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			fx_q        <= '0;
			fy_q        <= '0;
			dirty_q     <= 1'b0;
			dl_q        <= '0;
			dt_q        <= '0;
			dr_q        <= '0;
			db_q        <= '0;
			busy_q      <= 1'b0;
			wl_q        <= '0;
			wt_q        <= '0;
			wr_q        <= '0;
			wb_q        <= '0;
			hdr_q       <= '0;
			phase_q     <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			out_valid_q <= 1'b0;
			out_has_q   <= 1'b0;
			out_dnc_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_byte_q  <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_head.op)
							OP_FILL: begin
								fx_q    <= q_head.left;
								fy_q    <= q_head.top;
								state_q <= ST_FILL;
								dirty_q <= 1'b1;
								if (!dirty_q) begin
									dl_q <= q_head.left;
									dt_q <= q_head.top;
									dr_q <= q_head.right;
									db_q <= q_head.bottom;
								end else begin
									if (q_head.left < dl_q)   dl_q <= q_head.left;
									if (q_head.top < dt_q)    dt_q <= q_head.top;
									if (q_head.right > dr_q)  dr_q <= q_head.right;
									if (q_head.bottom > db_q) db_q <= q_head.bottom;
								end
							end
							OP_FLUSH_DIRTY: begin
								if (!busy_q && dirty_q) begin
									dirty_q <= 1'b0;
									if (!dirty_clip_empty) begin
										busy_q  <= 1'b1;
										hdr_q   <= '0;
										phase_q <= 1'b0;
										wl_q    <= dl_q;
										wt_q    <= dt_q;
										wr_q    <= dx1m[XW-1:0];
										wb_q    <= dy1m[XW-1:0];
										px_q    <= dl_q;
										py_q    <= dt_q;
									end
								end
							end
							OP_FLUSH_REGION: begin
								if (!busy_q) begin
									busy_q  <= 1'b1;
									hdr_q   <= '0;
									phase_q <= 1'b0;
									wl_q    <= q_head.left;
									wt_q    <= q_head.top;
									wr_q    <= q_head.right;
									wb_q    <= q_head.bottom;
									px_q    <= q_head.left;
									py_q    <= q_head.top;
								end
							end
							default: begin
								if (out_free) begin
									if (!busy_q) begin
										out_valid_q <= 1'b1;
										out_has_q   <= 1'b0;
										out_dnc_q   <= 1'b0;
										out_byte_q  <= 8'h00;
										out_last_q  <= 1'b0;
									end else if (hdr_q != HDR_BYTES) begin
										out_valid_q <= 1'b1;
										out_has_q   <= 1'b1;
										out_dnc_q   <= (hdr_q != 4'd0) && (hdr_q != 4'd5) &&
											(hdr_q != 4'd10);
										out_byte_q  <= hdr_byte;
										out_last_q  <= 1'b0;
										hdr_q       <= hdr_q + 1'b1;
									end else begin
										state_q <= ST_PULL_OUT;
									end
								end
							end
						endcase
					end
				end
				ST_FILL: begin
					if (fill_last) begin
						state_q <= ST_IDLE;
					end else if (fx_q == q_head.right) begin
						fx_q <= q_head.left;
						fy_q <= fy_q + 1'b1;
					end else begin
						fx_q <= fx_q + 1'b1;
					end
				end
				ST_PULL_OUT: begin
					out_valid_q <= 1'b1;
					out_has_q   <= 1'b1;
					out_dnc_q   <= 1'b1;
					out_byte_q  <= phase_q ? mem_rdata[7:0] : mem_rdata[15:8];
					out_last_q  <= pix_last;
					phase_q     <= !phase_q;
					if (phase_q) begin
						if (px_q == wr_q) begin
							px_q <= wl_q;
							py_q <= py_q + 1'b1;
						end else begin
							px_q <= px_q + 1'b1;
						end
					end
					if (pix_last) begin
						busy_q <= 1'b0;
						hdr_q  <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty            = !out_valid_q;
	assign has_byte         = out_has_q;
	assign data_not_command = out_dnc_q;
	assign out_byte         = out_byte_q;
	assign last_of_flush    = out_last_q;

	`FDF_ASSERT_HOLDS(a_pull_slot_free, clk, arst_n, (state_q == ST_PULL_OUT) |-> !out_valid_q)
	`FDF_ASSERT_NEXT(a_pull_gives_result, clk, arst_n, (state_q == ST_PULL_OUT), out_valid_q)
	`FDF_ASSERT_HOLDS(a_fill_has_head, clk, arst_n, (state_q == ST_FILL) |-> !q_empty)
	`FDF_ASSERT_HOLDS(a_stream_ends_on_last, clk, arst_n, $fell(busy_q) |-> (out_valid_q && out_last_q))
endmodule
`default_nettype wire

>>> hw/rtl/framebuffer_dirty_flush_engine_unit.sv
// top level of the framebuffer dirty flush engine: config registers and wiring
// depends on fdf_pkg, fdf_front, fdf_queue, fdf_back
//
// channel    handshake            payload
// command    push / full          command, pos_x, pos_y, rect_width, rect_height, pixel_color
// result     empty / pop          has_byte, data_not_command, out_byte, last_of_flush
// config     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// after reset the frame store is cleared one word a cycle, with full high
// a pull of a header byte or an idle pull is answered from the idle state; a pull of a
// pixel byte also passes the pull-out state (registered read of the frame store port)
// a pixel write or fill is set up from the idle state, then writes one clipped pixel a
// cycle on the single write port; flushes are taken from the idle state
// a two-entry queue parts the front end from the back end, so commands are taken
// while a fill walks or a result waits to be popped, until the queue is full
`default_nettype none
module framebuffer_dirty_flush_engine_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [2:0]         command,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] rect_width,
	input  wire logic signed [15:0] rect_height,
	input  wire logic [15:0]        pixel_color,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    has_byte,
	output logic                    data_not_command,
	output logic [7:0]              out_byte,
	output logic                    last_of_flush,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [8:0]         cfg_data
);
	import fdf_pkg::*;

	// register indexes of the config port
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_COLUMN_OFFSET = 3'd2;
	localparam logic [2:0] CFG_ROW_OFFSET    = 3'd3;

	logic [XW-1:0]    screen_width_q, screen_height_q;
	logic [OFS_W-1:0] column_offset_q, row_offset_q;
	logic [XW-1:0]    eff_w, eff_h;
	logic             init_done;
	logic             q_push, q_pop, q_full, q_empty;
	q_entry_t         q_in, q_head;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 9'd240;
			screen_height_q <= 9'd320;
			column_offset_q <= '0;
			row_offset_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				CFG_COLUMN_OFFSET: column_offset_q <= cfg_data[OFS_W-1:0];
				CFG_ROW_OFFSET:    row_offset_q    <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective size saturates at the store dimensions
	assign eff_w = (32'(screen_width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : screen_width_q;
	assign eff_h = (32'(screen_height_q) > MAX_HEIGHT) ? XW'(MAX_HEIGHT) : screen_height_q;

	// front end: accept, clip and classify
	fdf_front u_front (
		.push        (push),
		.full        (full),
		.command     (command),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.pixel_color (pixel_color),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.init_done   (init_done),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	// operation queue
	fdf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	// back end: store, dirty tracking and byte stream
	fdf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_head           (q_head),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.init_done        (init_done),
		.eff_w            (eff_w),
		.eff_h            (eff_h),
		.col_off          (column_offset_q),
		.row_off          (row_offset_q),
		.pop              (pop),
		.empty            (empty),
		.has_byte         (has_byte),
		.data_not_command (data_not_command),
		.out_byte         (out_byte),
		.last_of_flush    (last_of_flush)
	);
endmodule
`default_nettype wire

>>> tb/framebuffer_dirty_flush_engine_unit_tb.sv
// self-checking testbench of the framebuffer dirty flush engine
// predicts pulled panel bytes from a frame store model; depends on fdf_pkg and the rtl
`default_nettype none
module framebuffer_dirty_flush_engine_unit_tb;
	import fdf_pkg::*;

	// command codes of the request channel
	localparam logic [2:0] CMD_WRITE_PIXEL  = 3'd0;
	localparam logic [2:0] CMD_FILL_RECT    = 3'd1;
	localparam logic [2:0] CMD_FLUSH_DIRTY  = 3'd2;
	localparam logic [2:0] CMD_FLUSH_REGION = 3'd3;
	localparam logic [2:0] CMD_PULL_BYTE    = 3'd4;
	localparam logic [2:0] CMD_UNUSED_5     = 3'd5;
	localparam logic [2:0] CMD_UNUSED_6     = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7     = 3'd7;

	// configuration register indexes
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_COLUMN_OFFSET = 3'd2;
	localparam logic [2:0] REG_ROW_OFFSET    = 3'd3;
	localparam logic [2:0] REG_UNUSED        = 3'd7;

	// panel command bytes
	localparam logic [7:0] PANEL_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] PANEL_ROW_SET      = 8'h2B;
	localparam logic [7:0] PANEL_MEMORY_WRITE = 8'h2C;
	localparam int         HEADER_BYTES       = 11;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic [15:0]        color;
	} draw_req_t;

	typedef struct packed {
		logic       has_byte;
		logic       data_not_command;
		logic [7:0] out_byte;
		logic       last_of_flush;
	} panel_byte_t;

	// frame store model, dirty box tracking and flush stream prediction
	class flush_scoreboard;
		logic [15:0] pixels [STORE_DEPTH];
		int unsigned scr_w, scr_h, col_ofs, row_ofs;
		bit          dirty;
		int          d_left, d_top, d_right, d_bottom;
		int          win [4];
		bit          busy;
		int unsigned cursor;
		panel_byte_t pending_bytes [$];
		int          mismatches;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			scr_w = 240;
			scr_h = 320;
			col_ofs = 0;
			row_ofs = 0;
			dirty = 0;
			d_left = 0; d_top = 0; d_right = 0; d_bottom = 0;
			foreach (win[i]) win[i] = 0;
			busy = 0;
			cursor = 0;
			mismatches = 0;
		endfunction

		function int eff_w();
			return scr_w > MAX_WIDTH ? MAX_WIDTH : scr_w;
		endfunction

		function int eff_h();
			return scr_h > MAX_HEIGHT ? MAX_HEIGHT : scr_h;
		endfunction

		function void config_write(logic [2:0] idx, logic [8:0] data);
			case (idx)
				REG_SCREEN_WIDTH: scr_w = data;
				REG_SCREEN_HEIGHT: scr_h = data;
				REG_COLUMN_OFFSET: col_ofs = data[7:0];
				REG_ROW_OFFSET: row_ofs = data[7:0];
				default: ;
			endcase
		endfunction

		// clip in 32-bit arithmetic, inclusive box out
		function bit clip(int x, int y, int w, int h, output int b [4]);
			int x0, y0, x1, y1;
			x0 = x < 0 ? 0 : x;
			y0 = y < 0 ? 0 : y;
			x1 = x + w;
			y1 = y + h;
			if (x1 > eff_w()) x1 = eff_w();
			if (y1 > eff_h()) y1 = eff_h();
			b[0] = x0; b[1] = y0; b[2] = x1 - 1; b[3] = y1 - 1;
			return !(x1 <= x0 || y1 <= y0);
		endfunction

		function void grow_dirty(int b [4]);
			if (!dirty) begin
				d_left = b[0]; d_top = b[1]; d_right = b[2]; d_bottom = b[3];
				dirty = 1;
			end else begin
				if (b[0] < d_left) d_left = b[0];
				if (b[1] < d_top) d_top = b[1];
				if (b[2] > d_right) d_right = b[2];
				if (b[3] > d_bottom) d_bottom = b[3];
			end
		endfunction

		function void put_pixel(int x, int y, logic [15:0] c);
			longint idx;
			idx = longint'(y) * eff_w() + x;
			if (idx < STORE_DEPTH) pixels[idx] = c;
		endfunction

		function logic [15:0] get_pixel(int x, int y);
			longint idx;
			idx = longint'(y) * eff_w() + x;
			return idx < STORE_DEPTH ? pixels[idx] : 16'h0000;
		endfunction

		function void arm(int x, int y, int w, int h);
			int b [4];
			if (!clip(x, y, w, h, b)) return;
			win = b;
			busy = 1;
			cursor = 0;
		endfunction

		function int unsigned stream_total();
			return HEADER_BYTES + 2 * (win[2] - win[0] + 1) * (win[3] - win[1] + 1);
		endfunction

		function int unsigned bytes_left();
			return busy ? stream_total() - cursor : 0;
		endfunction

		function panel_byte_t stream_byte(int unsigned k);
			panel_byte_t r;
			int unsigned cx0, cx1, ry0, ry1, w, p;
			logic [15:0] c;
			cx0 = win[0] + col_ofs;
			cx1 = win[2] + col_ofs;
			ry0 = win[1] + row_ofs;
			ry1 = win[3] + row_ofs;
			r.has_byte = 1;
			r.data_not_command = 1;
			r.last_of_flush = 0;
			case (k)
				0: begin r.data_not_command = 0; r.out_byte = PANEL_COLUMN_SET; end
				1: r.out_byte = cx0[15:8];
				2: r.out_byte = cx0[7:0];
				3: r.out_byte = cx1[15:8];
				4: r.out_byte = cx1[7:0];
				5: begin r.data_not_command = 0; r.out_byte = PANEL_ROW_SET; end
				6: r.out_byte = ry0[15:8];
				7: r.out_byte = ry0[7:0];
				8: r.out_byte = ry1[15:8];
				9: r.out_byte = ry1[7:0];
				10: begin r.data_not_command = 0; r.out_byte = PANEL_MEMORY_WRITE; end
				default: begin
					w = win[2] - win[0] + 1;
					p = (k - HEADER_BYTES) >> 1;
					c = get_pixel(win[0] + p % w, win[1] + p / w);
					r.out_byte = ((k - HEADER_BYTES) & 1) ? c[7:0] : c[15:8];
				end
			endcase
			return r;
		endfunction

		// accepted request: update model, queue the byte a pull produces
		function void note_request(draw_req_t q);
			int b [4];
			int total;
			panel_byte_t r;
			case (q.command)
				CMD_WRITE_PIXEL: begin
					if (clip(q.x, q.y, 1, 1, b)) begin
						put_pixel(b[0], b[1], q.color);
						grow_dirty(b);
					end
				end
				CMD_FILL_RECT: begin
					if (clip(q.x, q.y, q.w, q.h, b)) begin
						for (int row = b[1]; row <= b[3]; row++)
							for (int col = b[0]; col <= b[2]; col++)
								put_pixel(col, row, q.color);
						grow_dirty(b);
					end
				end
				CMD_FLUSH_DIRTY: begin
					// ignored while a stream is pending or nothing is dirty
					if (!busy && dirty) begin
						arm(d_left, d_top, d_right - d_left + 1, d_bottom - d_top + 1);
						dirty = 0;
					end
				end
				CMD_FLUSH_REGION: begin
					if (!busy) arm(q.x, q.y, q.w, q.h);
				end
				CMD_PULL_BYTE: begin
					if (!busy) begin
						r = '0;
					end else begin
						total = stream_total();
						r = stream_byte(cursor);
						r.last_of_flush = (cursor + 1 >= total);
						if (cursor + 1 >= total) begin
							busy = 0;
							cursor = 0;
						end else begin
							cursor++;
						end
					end
					pending_bytes.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void report(string what, int e, int a);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h actual %0h", what, e, a);
		endfunction

		function void check_byte(panel_byte_t got);
			panel_byte_t want;
			if (pending_bytes.size() == 0) begin
				report("unexpected result", 0, got);
				return;
			end
			want = pending_bytes.pop_front();
			if (got.has_byte !== want.has_byte)
				report("has_byte", want.has_byte, got.has_byte);
			if (got.data_not_command !== want.data_not_command)
				report("data_not_command", want.data_not_command, got.data_not_command);
			if (got.out_byte !== want.out_byte)
				report("out_byte", want.out_byte, got.out_byte);
			if (got.last_of_flush !== want.last_of_flush)
				report("last_of_flush", want.last_of_flush, got.last_of_flush);
		endfunction

		function int waiting();
			return pending_bytes.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] rect_width;
	logic signed [15:0] rect_height;
	logic [15:0]        pixel_color;
	logic               empty;
	logic               pop;
	logic               has_byte;
	logic               data_not_command;
	logic [7:0]         out_byte;
	logic               last_of_flush;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [8:0]         cfg_data;

	framebuffer_dirty_flush_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.pixel_color(pixel_color),
		.empty(empty),
		.pop(pop),
		.has_byte(has_byte),
		.data_not_command(data_not_command),
		.out_byte(out_byte),
		.last_of_flush(last_of_flush),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	flush_scoreboard sb = new();

	// idle percentages of sender and receiver, and the receiver hold-off request
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_req = 0;
	int sent = 0;
	// effective screen size used to aim random coordinates
	int aim_w = 240;
	int aim_h = 320;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// every input known from time zero
	initial begin
		arst_n = 0;
		push = 0;
		command = CMD_PULL_BYTE;
		pos_x = '0;
		pos_y = '0;
		rect_width = '0;
		rect_height = '0;
		pixel_color = '0;
		pop = 0;
		cfg_valid = 0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
	end

	// generous ceiling: clearing pass, one full-screen fill and slow handshakes
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: check accepted results, then pick pop for the next edge
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_byte('{has_byte, data_not_command, out_byte, last_of_flush});
			if (rx_hold_req > 0) begin
				// long hold-off counted here
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// send one request, with a random gap ahead of it
	task automatic send(draw_req_t q);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		command <= q.command;
		pos_x <= q.x;
		pos_y <= q.y;
		rect_width <= q.w;
		rect_height <= q.h;
		pixel_color <= q.color;
		do @(posedge clk); while (full);
		sb.note_request(q);
		sent++;
	endtask

	task automatic send_cmd(int c, int x, int y, int w, int h, int color);
		draw_req_t q;
		q.command = 3'(c);
		q.x = 16'(x);
		q.y = 16'(y);
		q.w = 16'(w);
		q.h = 16'(h);
		q.color = 16'(color);
		send(q);
	endtask

	task automatic pull(int n);
		repeat (n) send_cmd(CMD_PULL_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// sender pause until every expected byte has come
	task automatic wait_drained();
		push <= 0;
		while (sb.waiting() > 0) @(posedge clk);
	endtask

	// a pull queues behind any fill still walking, so its result means idle
	task automatic settle();
		pull(1);
		wait_drained();
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.config_write(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_screen(int w, int h, int co, int ro);
		settle();
		write_reg(REG_SCREEN_WIDTH, 9'(w));
		write_reg(REG_SCREEN_HEIGHT, 9'(h));
		write_reg(REG_COLUMN_OFFSET, 9'(co));
		write_reg(REG_ROW_OFFSET, 9'(ro));
		aim_w = w > MAX_WIDTH ? MAX_WIDTH : (w == 0 ? 1 : w);
		aim_h = h > MAX_HEIGHT ? MAX_HEIGHT : (h == 0 ? 1 : h);
	endtask

	function automatic int near_coord(int span);
		return int'($urandom_range(span + 5)) - 3;
	endfunction

	// a few draws, a flush, then pulls that mostly drain the stream
	task automatic flush_sequence();
		int n, k;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(1))
				send_cmd(CMD_WRITE_PIXEL, near_coord(aim_w), near_coord(aim_h), $urandom,
					$urandom, $urandom);
			else
				send_cmd(CMD_FILL_RECT, near_coord(aim_w), near_coord(aim_h),
					int'($urandom_range(12)) - 2, int'($urandom_range(12)) - 2, $urandom);
		end
		if ($urandom_range(1))
			send_cmd(CMD_FLUSH_DIRTY, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send_cmd(CMD_FLUSH_REGION, near_coord(aim_w), near_coord(aim_h),
				int'($urandom_range(14)) - 2, int'($urandom_range(14)) - 2, $urandom);
		k = sb.bytes_left();
		if (k > 300) k = 300;
		pull(k + $urandom_range(2));
	endtask

	// full-range noise on every field, unused codes included
	task automatic noise_burst();
		repeat ($urandom_range(1, 6))
			send_cmd($urandom_range(7), $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int target;
		bit paused;
		paused = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed part at the reset screen of 240 by 320
		pull(1);                                                  // pull while idle
		send_cmd(CMD_WRITE_PIXEL, 0, 0, 0, 0, 16'hFFFF);
		send_cmd(CMD_WRITE_PIXEL, 239, 319, 0, 0, 16'h8001);
		send_cmd(CMD_WRITE_PIXEL, -1, 0, 0, 0, 16'h1111);         // dropped
		send_cmd(CMD_WRITE_PIXEL, 240, 5, 0, 0, 16'h2222);        // dropped
		send_cmd(CMD_WRITE_PIXEL, -32768, 32767, 0, 0, 16'h3333);
		send_cmd(CMD_FILL_RECT, -32768, -32768, 32767, 32767, 16'h4444); // clips empty
		send_cmd(CMD_FILL_RECT, 2, 3, 3, 2, 16'h1234);
		send_cmd(CMD_UNUSED_5, 1, 1, 1, 1, 16'h0001);
		send_cmd(CMD_UNUSED_6, 1, 1, 1, 1, 16'h0001);
		send_cmd(CMD_UNUSED_7, 1, 1, 1, 1, 16'h0001);
		send_cmd(CMD_FLUSH_REGION, -32768, 0, -32768, 4, 0);     // empty region
		send_cmd(CMD_FLUSH_REGION, 32767, 0, 32767, 4, 0);       // no 16-bit wrap
		send_cmd(CMD_FLUSH_REGION, 0, 0, 2, 1, 0);
		send_cmd(CMD_FLUSH_DIRTY, 0, 0, 0, 0, 0);                // ignored, stream pending
		pull(16);                                                 // last one idle again
		send_cmd(CMD_FILL_RECT, -5, -5, 32767, 32767, 16'hA5A5);  // whole screen
		set_screen(3, 2, 255, 200);
		send_cmd(CMD_FLUSH_DIRTY, 0, 0, 0, 0, 0);                // dirty box clipped to 3x2
		pull(23);
		send_cmd(CMD_FLUSH_DIRTY, 0, 0, 0, 0, 0);                // flag clear, nothing
		send_cmd(CMD_WRITE_PIXEL, 2, 1, 0, 0, 16'h5A5A);
		settle();
		write_reg(REG_SCREEN_WIDTH, 1);
		write_reg(REG_UNUSED, 9'h1FF);
		send_cmd(CMD_FLUSH_DIRTY, 0, 0, 0, 0, 0);                // box clips to nothing
		send_cmd(CMD_FLUSH_DIRTY, 0, 0, 0, 0, 0);
		pull(2);

		// random phases over idle modes and screen settings
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_screen(1, 1, 255, 255);
				2: set_screen(511, 9, 0, 0);
				3: set_screen(0, 5, $urandom_range(511), $urandom_range(511));
				4: set_screen(320, 1, 0, 255);
				default: set_screen($urandom_range(1, 24), $urandom_range(1, 16),
					$urandom_range(511), $urandom_range(511));
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 74; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 74; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			if (p == 1) begin
				// receiver holds off while requests pile up against full
				tx_idle_pct = 0;
				rx_hold_req = 500;
				send_cmd(CMD_FLUSH_REGION, 0, 0, 32767, 32767, 0);
				pull(40);
				tx_idle_pct = 74;
			end
			target = sent + 100;
			while (sent < target) begin
				if ($urandom_range(99) < 75) flush_sequence();
				else noise_burst();
				if (p == 2 && !paused && sent > target - 50) begin
					wait_drained();
					repeat (5) @(posedge clk);
					paused = 1;
				end
			end
		end

		push <= 0;
		while (sb.waiting() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
